[rtl/fbf_pkg.sv]
// Package for the first/best fit partition allocator.
// Holds mode and status codes, cell control types and reset constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbf_pkg;

  localparam int MaxSegmentsDef = 16;
  localparam int OwnerBitsDef   = 8;
  localparam int SizeBitsDef    = 16;
  localparam int CapBits        = 16;
  localparam int CapReset       = 1024;

  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_BEST   = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_NOOWNER = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_INIT  = 3'd1,
    OP_ALLOC = 3'd2,
    OP_FREE  = 3'd3,
    OP_MERGE = 3'd4
  } fbf_op_e;

  typedef struct packed {
    fbf_op_e op;
    logic    split;
  } fbf_ctrl_t;

endpackage
`default_nettype wire

[rtl/first_best_fit_partition_allocator.sv]
// An allocation scans the used entries in order (first fit stops at the first
// fit), then updates the table; a free marks the owner's entries free, then
// merges adjacent free pairs one at a time. The sequencer handles one beat at
// a time; the result register lets the next beat enter while a result waits.
// Reset, and a capacity write while idle, leave one free segment covering
// the whole capacity (1024 units after reset).
`timescale 1ns / 1ps
`default_nettype none
module first_best_fit_partition_allocator import fbf_pkg::*; #(
  parameter int MAX_SEGMENTS = MaxSegmentsDef,
  parameter int OWNER_BITS   = OwnerBitsDef,
  parameter int SIZE_BITS    = SizeBitsDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [CapBits-1:0]                  cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic [OWNER_BITS-1:0]               owner_id_i,
  input  wire logic [SIZE_BITS-1:0]                request_size_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [1:0]                          status_o,
  output logic      [SIZE_BITS-1:0]                start_address_o,
  output logic      [$clog2(MAX_SEGMENTS+1)-1:0]   segment_count_o
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_ALLOC = 6'b000100,
    S_FREE  = 6'b001000,
    S_MERGE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         used_q, used_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [1:0]            mode_q, mode_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [SIZE_BITS-1:0]  req_q, req_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         pick_q, pick_d;
  logic [SIZE_BITS-1:0]  pick_size_q, pick_size_d, pick_start_q, pick_start_d;
  logic [1:0]            res_stat_q, res_stat_d;
  logic [SIZE_BITS-1:0]  res_addr_q, res_addr_d;
  logic                  out_valid_q;
  logic [1:0]            out_stat_q;
  logic [SIZE_BITS-1:0]  out_addr_q;
  logic [CW-1:0]         out_cnt_q;

  fbf_ctrl_t             ctrl;
  logic [IW-1:0]         pos;
  logic [SIZE_BITS-1:0]  cap;

  logic [SIZE_BITS-1:0]  st [MAX_SEGMENTS];
  logic [SIZE_BITS-1:0]  sz [MAX_SEGMENTS];
  logic                  fr [MAX_SEGMENTS];
  logic [OWNER_BITS-1:0] ow [MAX_SEGMENTS];

  logic [MAX_SEGMENTS-1:0] owner_hit;
  logic [MAX_SEGMENTS-1:0] merge_here;
  logic                    any_merge;
  logic [IW-1:0]           merge_pos;
  logic                    fits, last;
  logic                    in_fire, out_load;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      logic [SIZE_BITS-1:0]  p_st, p_sz, n_st, n_sz;
      logic                  p_fr, n_fr;
      logic [OWNER_BITS-1:0] p_ow, n_ow;
      if (g == 0) begin : g_first
        assign p_st = '0;
        assign p_sz = '0;
        assign p_fr = 1'b0;
        assign p_ow = '0;
      end else begin : g_prev
        assign p_st = st[g-1];
        assign p_sz = sz[g-1];
        assign p_fr = fr[g-1];
        assign p_ow = ow[g-1];
      end
      if (g == MAX_SEGMENTS - 1) begin : g_last
        assign n_st = '0;
        assign n_sz = '0;
        assign n_fr = 1'b0;
        assign n_ow = '0;
      end else begin : g_next
        assign n_st = st[g+1];
        assign n_sz = sz[g+1];
        assign n_fr = fr[g+1];
        assign n_ow = ow[g+1];
      end
      fbf_cell #(
        .IDX(g), .MAX_SEGMENTS(MAX_SEGMENTS), .OWNER_BITS(OWNER_BITS), .SIZE_BITS(SIZE_BITS)
      ) u_cell (
        .clk_i, .rst_ni, .ctrl_i(ctrl), .pos_i(pos), .req_i(req_q), .owner_i(owner_q),
        .cap_i(cap),
        .prev_start_i(p_st), .prev_size_i(p_sz), .prev_free_i(p_fr), .prev_owner_i(p_ow),
        .next_start_i(n_st), .next_size_i(n_sz), .next_free_i(n_fr), .next_owner_i(n_ow),
        .start_o(st[g]), .size_o(sz[g]), .free_o(fr[g]), .owner_o(ow[g])
      );
      assign owner_hit[g] = (CW'(g) < used_q) && !fr[g] && (ow[g] == owner_q);
      if (g == MAX_SEGMENTS - 1) begin : g_nm
        assign merge_here[g] = 1'b0;
      end else begin : g_m
        assign merge_here[g] = (CW'(g + 1) < used_q) && fr[g] && fr[g+1];
      end
    end
  endgenerate

  always_comb begin
    merge_pos = '0;
    for (int j = MAX_SEGMENTS - 1; j >= 0; j--) begin
      if (merge_here[j]) merge_pos = IW'(j);
    end
  end
  assign any_merge = |merge_here;

  assign cap      = SIZE_BITS'(cfg_wdata_i);
  assign fits     = fr[idx_q] && (sz[idx_q] >= req_q);
  assign last     = ({1'b0, idx_q} + 1'b1) == (IW+1)'(used_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    idx_d        = idx_q;
    mode_d       = mode_q;
    owner_d      = owner_q;
    req_d        = req_q;
    found_d      = found_q;
    pick_d       = pick_q;
    pick_size_d  = pick_size_q;
    pick_start_d = pick_start_q;
    res_stat_d   = res_stat_q;
    res_addr_d   = res_addr_q;
    ctrl         = '{op: OP_HOLD, split: 1'b0};
    pos          = pick_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          ctrl   = '{op: OP_INIT, split: 1'b0};
          used_d = CW'(1);
        end else if (in_fire) begin
          mode_d     = mode_i;
          owner_d    = owner_id_i;
          req_d      = request_size_i;
          idx_d      = '0;
          found_d    = 1'b0;
          res_stat_d = STAT_OK;
          res_addr_d = '0;
          if (mode_i == MODE_FIRST || mode_i == MODE_BEST) begin
            if (request_size_i == '0) begin
              res_stat_d = STAT_NOFIT;
              state_d    = S_DONE;
            end else begin
              state_d = S_SCAN;
            end
          end else if (mode_i == MODE_FREE) begin
            state_d = S_FREE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (fits && (!found_q || (mode_q == MODE_BEST && sz[idx_q] < pick_size_q))) begin
          found_d      = 1'b1;
          pick_d       = idx_q;
          pick_size_d  = sz[idx_q];
          pick_start_d = st[idx_q];
        end
        idx_d = idx_q + 1'b1;
        if (last || (fits && mode_q == MODE_FIRST)) state_d = S_ALLOC;
      end
      S_ALLOC: begin
        state_d = S_DONE;
        if (!found_q) begin
          res_stat_d = STAT_NOFIT;
        end else if (pick_size_q > req_q && used_q >= MaxCnt) begin
          res_stat_d = STAT_FULL;
        end else begin
          ctrl       = '{op: OP_ALLOC, split: pick_size_q > req_q};
          res_addr_d = pick_start_q;
          if (pick_size_q > req_q) used_d = used_q + 1'b1;
        end
      end
      S_FREE: begin
        if (|owner_hit) begin
          ctrl    = '{op: OP_FREE, split: 1'b0};
          state_d = S_MERGE;
        end else begin
          res_stat_d = STAT_NOOWNER;
          state_d    = S_DONE;
        end
      end
      S_MERGE: begin
        pos = merge_pos;
        if (any_merge) begin
          ctrl   = '{op: OP_MERGE, split: 1'b0};
          used_d = used_q - 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= CW'(1);
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    owner_q      <= owner_d;
    req_q        <= req_d;
    pick_q       <= pick_d;
    pick_size_q  <= pick_size_d;
    pick_start_q <= pick_start_d;
    res_stat_q   <= res_stat_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      out_stat_q <= res_stat_q;
      out_addr_q <= res_addr_q;
      out_cnt_q  <= used_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign start_address_o = out_addr_q;
  assign segment_count_o = out_cnt_q;

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni) used_q != '0)
    else $error("segment count reached zero");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= MaxCnt)
    else $error("segment count exceeds table size");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");
  a_merge_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE && any_merge) |=> (used_q == $past(used_q) - 1'b1))
    else $error("merge did not remove an entry");

endmodule
`default_nettype wire

[rtl/fbf_cell.sv]
// One segment table entry of the allocator.
// Depends on fbf_pkg; loads from its lower or upper neighbor to shift the table.
`timescale 1ns / 1ps
`default_nettype none
module fbf_cell import fbf_pkg::*; #(
  parameter int IDX          = 0,
  parameter int MAX_SEGMENTS = MaxSegmentsDef,
  parameter int OWNER_BITS   = OwnerBitsDef,
  parameter int SIZE_BITS    = SizeBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbf_ctrl_t                     ctrl_i,
  input  wire logic [$clog2(MAX_SEGMENTS)-1:0] pos_i,
  input  wire logic [SIZE_BITS-1:0]          req_i,
  input  wire logic [OWNER_BITS-1:0]         owner_i,
  input  wire logic [SIZE_BITS-1:0]          cap_i,
  input  wire logic [SIZE_BITS-1:0]          prev_start_i,
  input  wire logic [SIZE_BITS-1:0]          prev_size_i,
  input  wire logic                          prev_free_i,
  input  wire logic [OWNER_BITS-1:0]         prev_owner_i,
  input  wire logic [SIZE_BITS-1:0]          next_start_i,
  input  wire logic [SIZE_BITS-1:0]          next_size_i,
  input  wire logic                          next_free_i,
  input  wire logic [OWNER_BITS-1:0]         next_owner_i,
  output logic      [SIZE_BITS-1:0]          start_o,
  output logic      [SIZE_BITS-1:0]          size_o,
  output logic                               free_o,
  output logic      [OWNER_BITS-1:0]         owner_o
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [IW:0] MyIdx = (IW+1)'(IDX);

  logic [SIZE_BITS-1:0]  start_q, start_d, size_q, size_d;
  logic                  free_q, free_d;
  logic [OWNER_BITS-1:0] owner_q, owner_d;
  logic [IW:0]           pos_ext;

  assign pos_ext = {1'b0, pos_i};

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    free_d  = free_q;
    owner_d = owner_q;
    case (ctrl_i.op)
      OP_INIT: begin
        if (IDX == 0) begin
          start_d = '0;
          size_d  = cap_i;
          free_d  = 1'b1;
          owner_d = '0;
        end
      end
      OP_ALLOC: begin
        if (MyIdx == pos_ext) begin
          size_d  = req_i;
          free_d  = 1'b0;
          owner_d = owner_i;
        end else if (ctrl_i.split && MyIdx == pos_ext + 1'b1) begin
          start_d = prev_start_i + req_i;
          size_d  = prev_size_i - req_i;
          free_d  = 1'b1;
          owner_d = '0;
        end else if (ctrl_i.split && MyIdx > pos_ext) begin
          start_d = prev_start_i;
          size_d  = prev_size_i;
          free_d  = prev_free_i;
          owner_d = prev_owner_i;
        end
      end
      OP_FREE: begin
        if (!free_q && owner_q == owner_i) begin
          free_d  = 1'b1;
          owner_d = '0;
        end
      end
      OP_MERGE: begin
        if (MyIdx == pos_ext) begin
          size_d = size_q + next_size_i;
        end else if (MyIdx > pos_ext) begin
          start_d = next_start_i;
          size_d  = next_size_i;
          free_d  = next_free_i;
          owner_d = next_owner_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      size_q  <= (IDX == 0) ? SIZE_BITS'(CapReset) : '0;
      free_q  <= (IDX == 0);
      owner_q <= '0;
    end else begin
      start_q <= start_d;
      size_q  <= size_d;
      free_q  <= free_d;
      owner_q <= owner_d;
    end
  end

  assign start_o = start_q;
  assign size_o  = size_q;
  assign free_o  = free_q;
  assign owner_o = owner_q;

endmodule
`default_nettype wire

[tb/sv/tb_first_best_fit_partition_allocator.sv]
// Testbench for the first/best fit partition allocator: random and directed
// requests with a scoreboard that mirrors the segment table. Depends on fbf_pkg.
`timescale 1ns / 1ps
module tb_first_best_fit_partition_allocator;
  import fbf_pkg::*;

  localparam int NSEG = MaxSegmentsDef;

  class alloc_scoreboard;
    logic [15:0] cap;
    logic [15:0] sstart[NSEG];
    logic [15:0] ssize[NSEG];
    bit          sfree[NSEG];
    logic [7:0]  sowner[NSEG];
    int          used;
    logic [1:0]  exp_status[$];
    logic [15:0] exp_addr[$];
    logic [4:0]  exp_count[$];
    int          errors;
    int          checked;
    int          full_hits;

    function void load(logic [15:0] c);
      cap = c;
      for (int i = 0; i < NSEG; i++) begin
        sstart[i] = 0; ssize[i] = 0; sfree[i] = 0; sowner[i] = 0;
      end
      ssize[0] = c;
      sfree[0] = 1;
      used = 1;
    endfunction

    function void open_at(int pos);
      for (int i = used; i > pos; i--) begin
        sstart[i] = sstart[i-1]; ssize[i] = ssize[i-1];
        sfree[i] = sfree[i-1]; sowner[i] = sowner[i-1];
      end
      used++;
    endfunction

    function void close_at(int pos);
      for (int i = pos; i + 1 < used; i++) begin
        sstart[i] = sstart[i+1]; ssize[i] = ssize[i+1];
        sfree[i] = sfree[i+1]; sowner[i] = sowner[i+1];
      end
      used--;
    endfunction

    function void note_request(logic [1:0] mode, logic [7:0] own, logic [15:0] req);
      logic [1:0]  st;
      logic [15:0] addr;
      int          pick;
      logic [15:0] waste;
      bit          found;
      int          i;
      st = STAT_OK;
      addr = 0;
      if (mode == MODE_FIRST || mode == MODE_BEST) begin
        pick = NSEG;
        waste = 0;
        if (req != 0) begin
          for (i = 0; i < used; i++) begin
            if (sfree[i] && ssize[i] >= req) begin
              if (mode == MODE_FIRST) begin
                pick = i;
                break;
              end
              if (pick == NSEG || ssize[i] - req < waste) begin
                pick = i;
                waste = ssize[i] - req;
              end
            end
          end
        end
        if (pick == NSEG) begin
          st = STAT_NOFIT;
        end else if (ssize[pick] > req && used >= NSEG) begin
          st = STAT_FULL;
          full_hits++;
        end else begin
          if (ssize[pick] > req) begin
            open_at(pick + 1);
            sstart[pick+1] = sstart[pick] + req;
            ssize[pick+1] = ssize[pick] - req;
            sfree[pick+1] = 1;
            sowner[pick+1] = 0;
          end
          ssize[pick] = req;
          sfree[pick] = 0;
          sowner[pick] = own;
          addr = sstart[pick];
        end
      end else if (mode == MODE_FREE) begin
        found = 0;
        for (i = 0; i < used; i++) begin
          if (!sfree[i] && sowner[i] == own) begin
            sfree[i] = 1;
            sowner[i] = 0;
            found = 1;
          end
        end
        if (!found) begin
          st = STAT_NOOWNER;
        end else begin
          i = 0;
          while (i + 1 < used) begin
            if (sfree[i] && sfree[i+1]) begin
              ssize[i] = ssize[i] + ssize[i+1];
              close_at(i + 1);
            end else begin
              i++;
            end
          end
        end
      end
      exp_status = {exp_status, st};
      exp_addr = {exp_addr, addr};
      exp_count = {exp_count, 5'(used)};
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [15:0] addr, logic [4:0] cnt);
      logic [1:0]  es;
      logic [15:0] ea;
      logic [4:0]  ec;
      if (exp_status.size() == 0) begin
        report("outstanding beats", 1, 0);
        return;
      end
      es = exp_status.pop_front();
      ea = exp_addr.pop_front();
      ec = exp_count.pop_front();
      checked++;
      if (st !== es) report("status", st, es);
      if (addr !== ea) report("start_address", addr, ea);
      if (cnt !== ec) report("segment_count", cnt, ec);
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  mode_i = 0;
  logic [7:0]  owner_id_i = 0;
  logic [15:0] request_size_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  status_o;
  logic [15:0] start_address_o;
  logic [4:0]  segment_count_o;

  alloc_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int total_sent = 0;

  first_best_fit_partition_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .mode_i(mode_i), .owner_id_i(owner_id_i), .request_size_i(request_size_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .status_o(status_o), .start_address_o(start_address_o),
    .segment_count_o(segment_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(status_o, start_address_o, segment_count_o);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(logic [1:0] mode, logic [7:0] own, logic [15:0] req);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= mode;
    owner_id_i <= own;
    request_size_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(mode, own, req);
    total_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [15:0] c);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.load(c);
  endtask

  task automatic random_request(int capval);
    int r;
    logic [15:0] req;
    r = $urandom_range(99);
    if (r < 8) req = $urandom();
    else if (r < 14) req = 0;
    else if (r < 40) req = $urandom_range(1, 8);
    else req = $urandom_range(1, (capval > 16) ? capval / 6 : 4);
    r = $urandom_range(99);
    if (r < 2) send_request(MODE_IGNORE, $urandom(), $urandom());
    else if (r < 30) send_request(MODE_FREE, $urandom_range(0, 7), $urandom());
    else if (r < 33) send_request(MODE_FREE, $urandom(), req);
    else if (r < 65) send_request(MODE_FIRST, $urandom_range(0, 7), req);
    else if (r < 68) send_request(MODE_FIRST, $urandom(), req);
    else send_request(MODE_BEST, $urandom_range(0, 7), req);
  endtask

  initial begin
    int caps[6];
    sb = new();
    sb.load(16'(CapReset));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed beats: extremes, exact fit, full table, absent owner, mode 3.
    send_request(MODE_FIRST, 8'd1, 16'd0);
    send_request(MODE_FIRST, 8'd1, 16'hFFFF);
    send_request(MODE_FIRST, 8'hFF, 16'd100);
    send_request(MODE_BEST, 8'd2, 16'd200);
    send_request(MODE_FIRST, 8'd3, 16'd50);
    send_request(MODE_FREE, 8'd2, 16'hFFFF);
    send_request(MODE_BEST, 8'd4, 16'd150);
    send_request(MODE_FREE, 8'd9, 16'd0);
    send_request(MODE_IGNORE, 8'hAA, 16'h5555);
    send_request(MODE_FREE, 8'hFF, 16'd1);
    for (int i = 0; i < 16; i++) send_request(MODE_FIRST, 8'(i), 16'd1);
    send_request(MODE_BEST, 8'd7, 16'd900);
    send_request(MODE_FIRST, 8'd7, 16'd1);
    send_request(MODE_FREE, 8'd0, 16'd0);

    write_capacity(16'd0);
    send_request(MODE_BEST, 8'd1, 16'd1);
    send_request(MODE_FREE, 8'd1, 16'd1);
    write_capacity(16'hFFFF);
    send_request(MODE_FIRST, 8'h55, 16'hFFFF);
    send_request(MODE_FREE, 8'h55, 16'd0);

    caps = '{1, 64, 1024, 300, 65535, 17};
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(16'(caps[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      for (int k = 0; k < 140; k++) begin
        if (k == 70) drain();
        random_request(caps[ph]);
      end
    end

    drain();
    $display("Sent %0d requests over 8 capacity settings, checked %0d results,",
             total_sent, sb.checked);
    $display("table-full refusals seen: %0d", sb.full_hits);
    if (sb.errors == 0 && sb.exp_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[first_best_fit_partition_allocator.f]
rtl/fbf_pkg.sv
rtl/fbf_cell.sv
rtl/first_best_fit_partition_allocator.sv
tb/sv/tb_first_best_fit_partition_allocator.sv
